[rtl/shdi_pkg.sv]
// Shared types and constants for the sample history derivative/integral core.
// No dependencies; imported by every module of the block.
package shdi_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int SECS_W   = 16;
  localparam int RESULT_W = 30;

  // Default history depth (legal range 5 to 17; deeper histories overflow the 30-bit integral)
  localparam int DEFAULT_HISTORY_DEPTH = 16;

  // Derivative needs five seconds of data
  localparam logic [SECS_W-1:0] DERIV_MIN_SECONDS = 16'd5;

  // Five-point backward difference coefficients, scaled by 1000
  localparam logic signed [RESULT_W-1:0] COEF_D0 = 30'sd2083;
  localparam logic signed [RESULT_W-1:0] COEF_D1 = 30'sd4000;
  localparam logic signed [RESULT_W-1:0] COEF_D2 = 30'sd3000;
  localparam logic signed [RESULT_W-1:0] COEF_D3 = 30'sd1333;
  localparam logic signed [RESULT_W-1:0] COEF_D4 = 30'sd250;

  // Trapezoid weights, scaled by 1000
  localparam logic signed [RESULT_W-1:0] COEF_FULL = 30'sd1000;
  localparam logic signed [RESULT_W-1:0] COEF_HALF = 30'sd500;

  // Slots in the queue between front and back
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  // One classified request as handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] h0;
    logic signed [SAMPLE_W-1:0] h1;
    logic signed [SAMPLE_W-1:0] h2;
    logic signed [SAMPLE_W-1:0] h3;
    logic signed [SAMPLE_W-1:0] h4;
    logic signed [SAMPLE_W-1:0] h_last;
    logic signed [RESULT_W-1:0] hist_sum;
    logic                       deriv_en;
    logic                       integ_en;
  } shdi_entry_t;

endpackage

[rtl/shdi_front.sv]
// Front end: holds the sample history and its running sum, classifies gating.
// Depends on shdi_pkg.
module shdi_front import shdi_pkg::*; #(
  parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [SECS_W-1:0]          seconds_since_epoch,
  output shdi_entry_t                entry
);

  localparam int SUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH) + 1;
  localparam logic [SECS_W-1:0] INTEG_MIN_SECONDS = SECS_W'(HISTORY_DEPTH);

  logic signed [SAMPLE_W-1:0] hist_r [HISTORY_DEPTH];
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SUM_W-1:0]    sample_x;
  logic signed [SUM_W-1:0]    oldest_x;

  // Running sum of all entries: add the new sample, drop the oldest
  always_comb begin
    sample_x = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    oldest_x = {{(SUM_W-SAMPLE_W){hist_r[HISTORY_DEPTH-1][SAMPLE_W-1]}},
                hist_r[HISTORY_DEPTH-1]};
    sum_nxt  = sum_r + sample_x - oldest_x;
  end

  // History shift line, newest at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= '0;
      sum_r <= '0;
    end else if (push) begin
      hist_r[0] <= sample;
      for (int i = 1; i < HISTORY_DEPTH; i++) hist_r[i] <= hist_r[i-1];
      sum_r <= sum_nxt;
    end
  end

  // Request built from the history as it will stand after this push
  always_comb begin
    entry.h0       = sample;
    entry.h1       = hist_r[0];
    entry.h2       = hist_r[1];
    entry.h3       = hist_r[2];
    entry.h4       = hist_r[3];
    entry.h_last   = hist_r[HISTORY_DEPTH-2];
    entry.hist_sum = {{(RESULT_W-SUM_W){sum_nxt[SUM_W-1]}}, sum_nxt};
    entry.deriv_en = (seconds_since_epoch >= DERIV_MIN_SECONDS);
    entry.integ_en = (seconds_since_epoch >= INTEG_MIN_SECONDS);
  end

endmodule

[rtl/shdi_queue.sv]
// Small FIFO of classified requests between front and back.
// Depends on shdi_pkg.
module shdi_queue import shdi_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  shdi_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output shdi_entry_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  shdi_entry_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Occupancy tracking
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

[rtl/shdi_back.sv]
// Back end: constant-coefficient products, then sums, gating and output register.
// Depends on shdi_pkg.
module shdi_back import shdi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  shdi_entry_t                q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RESULT_W-1:0] out_derivative,
  output logic signed [RESULT_W-1:0] out_integral
);

  logic advance;

  logic signed [RESULT_W-1:0] x0, x1, x2, x3, x4, x_ends;

  // Product stage
  logic                       s1_valid_r;
  logic signed [RESULT_W-1:0] p0_r, p1_r, p2_r, p3_r, p4_r;
  logic signed [RESULT_W-1:0] p_full_r, p_ends_r;
  logic                       deriv_en_r, integ_en_r;

  // Output stage
  logic                       out_valid_r;
  logic signed [RESULT_W-1:0] deriv_r, deriv_nxt;
  logic signed [RESULT_W-1:0] integ_r, integ_nxt;

  // Pipeline moves whenever the output register is free or being taken
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && q_not_empty;

  // Sign-extend history taps to result width
  always_comb begin
    x0 = {{(RESULT_W-SAMPLE_W){q_head.h0[SAMPLE_W-1]}}, q_head.h0};
    x1 = {{(RESULT_W-SAMPLE_W){q_head.h1[SAMPLE_W-1]}}, q_head.h1};
    x2 = {{(RESULT_W-SAMPLE_W){q_head.h2[SAMPLE_W-1]}}, q_head.h2};
    x3 = {{(RESULT_W-SAMPLE_W){q_head.h3[SAMPLE_W-1]}}, q_head.h3};
    x4 = {{(RESULT_W-SAMPLE_W){q_head.h4[SAMPLE_W-1]}}, q_head.h4};
    x_ends = x0 + {{(RESULT_W-SAMPLE_W){q_head.h_last[SAMPLE_W-1]}}, q_head.h_last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p0_r       <= x0 * COEF_D0;
      p1_r       <= x1 * COEF_D1;
      p2_r       <= x2 * COEF_D2;
      p3_r       <= x3 * COEF_D3;
      p4_r       <= x4 * COEF_D4;
      p_full_r   <= q_head.hist_sum * COEF_FULL;
      p_ends_r   <= x_ends * COEF_HALF;
      deriv_en_r <= q_head.deriv_en;
      integ_en_r <= q_head.integ_en;
    end
  end

  // Sums with gating; integral is 1000*sum minus 500*(newest + oldest)
  always_comb begin
    deriv_nxt = deriv_en_r ? (p0_r - p1_r + p2_r - p3_r + p4_r) : '0;
    integ_nxt = integ_en_r ? (p_full_r - p_ends_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      deriv_r <= deriv_nxt;
      integ_r <= integ_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_derivative = deriv_r;
  assign out_integral   = integ_r;

endmodule

[rtl/sample_history_derivative_integral_core.sv]
// Sample history derivative/integral core: top level.
// Depends on shdi_pkg, shdi_front, shdi_queue and shdi_back.
//
// Each accepted request pushes a signed 16-bit sample into a history of
// HISTORY_DEPTH entries and yields one result: a five-point backward difference
// scaled by 1000 (zero while seconds_since_epoch < 5) and the trapezoid
// integral of the whole history scaled by 1000 (zero while seconds_since_epoch
// < HISTORY_DEPTH). The block takes one request per clock cycle while its
// queue is not full; an accepted request passes through a queue slot, the
// product stage and the output register on its way to the output. The integral
// comes from a running sum that the front updates on every push, so its cost
// does not grow with the depth. A four-slot queue between front and back absorbs
// output stalls; in_stall rises only when that queue is full.
module sample_history_derivative_integral_core import shdi_pkg::*; #(
  parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH,
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [SECS_W-1:0]          in_seconds_since_epoch,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RESULT_W-1:0] out_derivative,
  output logic signed [RESULT_W-1:0] out_integral
);

  logic        push;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  shdi_entry_t push_entry;
  shdi_entry_t q_head;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  shdi_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .sample              (in_sample),
    .seconds_since_epoch (in_seconds_since_epoch),
    .entry               (push_entry)
  );

  shdi_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  shdi_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_derivative (out_derivative),
    .out_integral   (out_integral)
  );

endmodule

[tb/tb_sample_history_derivative_integral_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sample_history_derivative_integral_core.
// Depends on shdi_pkg and the core RTL; drives directed then random requests.
module tb_sample_history_derivative_integral_core;
  import shdi_pkg::*;

  localparam int DEPTH        = DEFAULT_HISTORY_DEPTH;
  localparam int STUCK_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 375;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    logic signed [RESULT_W-1:0] derivative;
    logic signed [RESULT_W-1:0] integral;
  } result_t;

  // One directed row; the typed-in result applies to the last repetition only
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SECS_W-1:0]          secs;
    int                         reps;
    bit                         typed;
    logic signed [RESULT_W-1:0] derivative;
    logic signed [RESULT_W-1:0] integral;
  } directed_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [SECS_W-1:0]          in_seconds_since_epoch;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [RESULT_W-1:0] out_derivative;
  logic signed [RESULT_W-1:0] out_integral;

  // Predictor state and scoreboard
  logic signed [SAMPLE_W-1:0] sample_history [DEPTH];
  result_t                    pending_results [$];
  bit                         typed_en;
  result_t                    typed_result;
  int                         mismatch_count;
  int                         stuck_cycles;
  int                         idle_pct;
  int                         stall_pct;

  sample_history_derivative_integral_core #(
    .HISTORY_DEPTH(DEPTH)
  ) uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample             (in_sample),
    .in_seconds_since_epoch(in_seconds_since_epoch),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_derivative        (out_derivative),
    .out_integral          (out_integral)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Push the sample into the history and form both gated sums
  function automatic result_t push_and_differentiate(input logic signed [SAMPLE_W-1:0] s,
                                                     input logic [SECS_W-1:0] secs);
    result_t r;
    longint  d_acc;
    longint  i_acc;
    for (int k = DEPTH - 1; k > 0; k--) sample_history[k] = sample_history[k-1];
    sample_history[0] = s;
    d_acc = 0;
    i_acc = 0;
    if (secs >= 5) begin
      d_acc = 2083 * longint'(sample_history[0]) - 4000 * longint'(sample_history[1])
            + 3000 * longint'(sample_history[2]) - 1333 * longint'(sample_history[3])
            + 250 * longint'(sample_history[4]);
    end
    if (secs >= DEPTH) begin
      i_acc = 500 * (longint'(sample_history[0]) + longint'(sample_history[DEPTH-1]));
      for (int k = 1; k < DEPTH - 1; k++) i_acc += 1000 * longint'(sample_history[k]);
    end
    r.derivative = d_acc[RESULT_W-1:0];
    r.integral   = i_acc[RESULT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one request, with a random idle gap ahead of it; returns at a falling edge
  task automatic push_request(input logic signed [SAMPLE_W-1:0] s,
                              input logic [SECS_W-1:0] secs,
                              input bit typed, input result_t want);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid               = 1'b1;
    in_sample              = s;
    in_seconds_since_epoch = secs;
    typed_en               = typed;
    typed_result           = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Predict on each accepted request, check each accepted result, watch for a hang
  always @(posedge clk) begin : scoreboard
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      want = push_and_differentiate(in_sample, in_seconds_since_epoch);
      if (typed_en) want = typed_result;
      pending_results.push_back(want);
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result derivative=%0d integral=%0d",
                                  out_derivative, out_integral));
      end else begin
        want = pending_results.pop_front();
        if (out_derivative !== want.derivative)
          report_mismatch($sformatf("derivative got %0d want %0d",
                                    out_derivative, want.derivative));
        if (out_integral !== want.integral)
          report_mismatch($sformatf("integral got %0d want %0d",
                                    out_integral, want.integral));
      end
    end
    stuck_cycles = moved ? 0 : stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t rows [12];
    int            idle_by_phase [4];
    int            stall_by_phase [4];
    result_t       none;
    result_t       want;
    logic signed [SAMPLE_W-1:0] s;
    logic [SECS_W-1:0]          secs;

    in_valid               = 1'b0;
    in_sample              = '0;
    in_seconds_since_epoch = '0;
    typed_en               = 1'b0;
    typed_result           = '0;
    mismatch_count         = 0;
    stuck_cycles           = 0;
    idle_pct               = 0;
    stall_pct              = 0;
    none                   = '0;
    foreach (sample_history[k]) sample_history[k] = '0;
    idle_by_phase  = '{0, 62, 0, 18};
    stall_by_phase = '{0, 0, 62, 18};

    // Directed: extremes, both gate boundaries, early history, alternating peaks
    rows = '{
      '{16'sh7FFF, 16'hFFFF, 1, 1'b1, 30'sd68253661, 30'sd16383500},  // first after reset
      '{16'sh8000, 16'd4,    1, 1'b1, 30'sd0, 30'sd0},                // both gated off
      '{16'sh8000, 16'd5,    1, 1'b0, 30'sd0, 30'sd0},                // derivative only
      '{16'sh7FFF, 16'd15,   1, 1'b0, 30'sd0, 30'sd0},
      '{16'sh8000, 16'd16,   1, 1'b0, 30'sd0, 30'sd0},                // integral turns on
      '{16'sh7FFF, 16'h8000, 1, 1'b0, 30'sd0, 30'sd0},
      '{16'sh8000, 16'h5555, 1, 1'b0, 30'sd0, 30'sd0},
      '{16'sh7FFF, 16'd10,   1, 1'b1, 30'sd349498155, 30'sd0},        // derivative maximum
      '{16'sh8000, 16'd5,    1, 1'b1, -30'sd349498155, 30'sd0},       // derivative minimum
      '{16'sh7FFF, 16'd100,  16, 1'b1, 30'sd0, 30'sd491505000},       // integral maximum
      '{16'sh8000, 16'hFFFF, 16, 1'b1, 30'sd0, -30'sd491520000},      // integral minimum
      '{16'sh0000, 16'hAAAA, 1, 1'b0, 30'sd0, 30'sd0}
    };

    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[r]) begin
      want.derivative = rows[r].derivative;
      want.integral   = rows[r].integral;
      for (int n = 0; n < rows[r].reps; n++)
        push_request(rows[r].sample, rows[r].secs,
                     rows[r].typed && (n == rows[r].reps - 1), want);
    end

    // Random: one phase per idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(9))
          0:       s = 16'sh7FFF;
          1:       s = 16'sh8000;
          default: s = SAMPLE_W'($urandom);
        endcase
        if ($urandom_range(4) == 0) secs = SECS_W'($urandom_range(20));
        else                        secs = SECS_W'($urandom);
        push_request(s, secs, 1'b0, none);
      end
    end

    in_valid = 1'b0;
    typed_en = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
